/* rtl/vn_pkg.sv */
// ----------------------------------------------------------------------------
// vn_pkg: shared types and constants for the q15 vector normalizer
// Holds the payload structs, datapath widths and the sideband carried
// alongside the square root and divider pipelines.
// ----------------------------------------------------------------------------
package vn_pkg;

	localparam int SAMPLE_W = 16;
	localparam int SUMSQ_W  = 32;
	localparam int ROOT_W   = 16;
	localparam int NUM_W    = 31;
	localparam int THRESH_W = 15;

	localparam logic [15:0]         Q15_ONE      = 16'd32767;
	localparam logic [THRESH_W-1:0] THRESH_RESET = 15'd26841;

	// root and quotient bits resolved per pipeline stage
	localparam int STEPS_PER_STAGE = 2;
	localparam int ROOT_STAGES     = ROOT_W / STEPS_PER_STAGE;
	localparam int DIV_STAGES      = ROOT_W / STEPS_PER_STAGE;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample_x;
		logic signed [SAMPLE_W-1:0] sample_y;
		logic signed [SAMPLE_W-1:0] sample_z;
	} vn_in_t;

	typedef struct packed {
		logic signed [15:0] unit_x;
		logic signed [15:0] unit_y;
		logic signed [15:0] unit_z;
		logic [15:0]        vector_magnitude;
		logic               too_aligned;
		logic               zero_vector;
	} vn_out_t;

	// per-item data that rides along with the root search
	typedef struct packed {
		logic             zero;
		logic [2:0]       neg;
		logic [NUM_W-1:0] num_x;
		logic [NUM_W-1:0] num_y;
		logic [NUM_W-1:0] num_z;
	} vn_side_t;

endpackage

/* rtl/vn_sqrt.sv */
// ----------------------------------------------------------------------------
// vn_sqrt: pipelined floor square root
// Restoring digit-by-digit root, two root bits per register stage, with the
// item sideband delayed alongside.
// ----------------------------------------------------------------------------
module vn_sqrt (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         valid_in,
	input  logic [vn_pkg::SUMSQ_W-1:0]   arg,
	input  vn_pkg::vn_side_t             side_in,
	output logic                         valid_out,
	output logic [vn_pkg::ROOT_W-1:0]    root,
	output vn_pkg::vn_side_t             side_out
);

	localparam int STAGES = vn_pkg::ROOT_STAGES;
	localparam int STEPS  = vn_pkg::STEPS_PER_STAGE;
	localparam int RW     = vn_pkg::ROOT_W;
	localparam int AW     = vn_pkg::SUMSQ_W;

	logic                 valid_s [STAGES+1];
	logic [AW-1:0]        rem_s   [STAGES+1];
	logic [RW-1:0]        root_s  [STAGES+1];
	vn_pkg::vn_side_t     side_s  [STAGES+1];

	assign valid_s[0] = valid_in;
	assign rem_s[0]   = arg;
	assign root_s[0]  = '0;
	assign side_s[0]  = side_in;

	for (genvar g = 0; g < STAGES; g++) begin : g_stage
		logic [AW-1:0] rem_nx;
		logic [RW-1:0] root_nx;

		// two root bits: trial = 2*root*2^b + 2^(2b)
		always_comb begin
			logic [AW+1:0] trial;
			rem_nx  = rem_s[g];
			root_nx = root_s[g];
			for (int k = 0; k < STEPS; k++) begin
				trial = ((AW+2)'(root_nx) << (RW - g*STEPS - k))
					| ((AW+2)'(1) << (2*(RW - 1 - g*STEPS - k)));
				if ((AW+2)'(rem_nx) >= trial) begin
					rem_nx  = rem_nx - trial[AW-1:0];
					root_nx = root_nx | (RW'(1) << (RW - 1 - g*STEPS - k));
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[g+1] <= 1'b0;
			end else begin
				valid_s[g+1] <= valid_s[g];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[g+1]  <= rem_nx;
			root_s[g+1] <= root_nx;
			side_s[g+1] <= side_s[g];
		end
	end

	assign valid_out = valid_s[STAGES];
	assign root      = root_s[STAGES];
	assign side_out  = side_s[STAGES];

endmodule

/* rtl/vn_div.sv */
// ----------------------------------------------------------------------------
// vn_div: pipelined three-lane divider
// Restoring long division of each scaled component magnitude by the root,
// two quotient bits per register stage.
// ----------------------------------------------------------------------------
module vn_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         valid_in,
	input  logic [vn_pkg::ROOT_W-1:0]    mag_in,
	input  vn_pkg::vn_side_t             side_in,
	output logic                         valid_out,
	output logic [vn_pkg::ROOT_W-1:0]    mag_out,
	output logic [2:0]                   neg_out,
	output logic                         zero_out,
	output logic [vn_pkg::ROOT_W-1:0]    quot [3]
);

	localparam int STAGES = vn_pkg::DIV_STAGES;
	localparam int STEPS  = vn_pkg::STEPS_PER_STAGE;
	localparam int QW     = vn_pkg::ROOT_W;
	localparam int NW     = vn_pkg::NUM_W;

	logic          valid_s [STAGES+1];
	logic [QW-1:0] mag_s   [STAGES+1];
	logic [2:0]    neg_s   [STAGES+1];
	logic          zero_s  [STAGES+1];
	logic [NW-1:0] num_s   [STAGES+1][3];
	logic [QW-1:0] rem_s   [STAGES+1][3];
	logic [QW-1:0] quo_s   [STAGES+1][3];

	assign valid_s[0]  = valid_in;
	assign mag_s[0]    = mag_in;
	assign neg_s[0]    = side_in.neg;
	assign zero_s[0]   = side_in.zero;
	assign num_s[0][0] = side_in.num_x;
	assign num_s[0][1] = side_in.num_y;
	assign num_s[0][2] = side_in.num_z;

	// high numerator bits start the remainder; they are below the divisor
	for (genvar l = 0; l < 3; l++) begin : g_init
		assign rem_s[0][l] = QW'(num_s[0][l][NW-1:QW]);
		assign quo_s[0][l] = '0;
	end

	for (genvar g = 0; g < STAGES; g++) begin : g_stage
		logic [QW-1:0] rem_nx [3];
		logic [QW-1:0] quo_nx [3];

		for (genvar l = 0; l < 3; l++) begin : g_lane
			// shift in the next numerator bit, subtract when it fits
			always_comb begin
				logic [QW:0] part;
				rem_nx[l] = rem_s[g][l];
				quo_nx[l] = quo_s[g][l];
				for (int k = 0; k < STEPS; k++) begin
					part = {rem_nx[l], num_s[g][l][QW - 1 - g*STEPS - k]};
					if (part >= {1'b0, mag_s[g]}) begin
						part      = part - {1'b0, mag_s[g]};
						quo_nx[l] = quo_nx[l] | (QW'(1) << (QW - 1 - g*STEPS - k));
					end
					rem_nx[l] = part[QW-1:0];
				end
			end

			always_ff @(posedge clk) begin
				num_s[g+1][l] <= num_s[g][l];
				rem_s[g+1][l] <= rem_nx[l];
				quo_s[g+1][l] <= quo_nx[l];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[g+1] <= 1'b0;
			end else begin
				valid_s[g+1] <= valid_s[g];
			end
		end

		always_ff @(posedge clk) begin
			mag_s[g+1]  <= mag_s[g];
			neg_s[g+1]  <= neg_s[g];
			zero_s[g+1] <= zero_s[g];
		end
	end

	assign valid_out = valid_s[STAGES];
	assign mag_out   = mag_s[STAGES];
	assign neg_out   = neg_s[STAGES];
	assign zero_out  = zero_s[STAGES];
	assign quot[0]   = quo_s[STAGES][0];
	assign quot[1]   = quo_s[STAGES][1];
	assign quot[2]   = quo_s[STAGES][2];

endmodule

/* rtl/vector_normalize_q15_core.sv */
// ----------------------------------------------------------------------------
// vector_normalize_q15_core: q15 unit vector of a three-axis sample
// Squares and sums the components, takes the floor square root, divides
// each component times 32767 by it and flags alignment with the y axis.
// ----------------------------------------------------------------------------
// Usage:
//   input: drive sample and raise start; a transfer happens at a clock edge
//   with start high and busy low. busy stays low, so a sample may be given
//   in every cycle.
//   output: each result shows on result for one cycle with done high; the
//   receiver cannot stall and must take it in that cycle.
//   config: cfg_data is written into the cosine threshold on a transfer
//   with cfg_valid and cfg_ready high; cfg_ready is always high. Write it
//   only while no sample is in flight.
//   pipeline: each sample passes through one stage of squares, one of the
//   sum, eight stages of the root search (two root bits each), eight of the
//   divider (two quotient bits each) and the output register.
//   throughput: one sample per cycle, set by the fully pipelined datapath.
//   reset: clears all valid bits and loads the threshold with 26841.
// ----------------------------------------------------------------------------
module vector_normalize_q15_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  vn_pkg::vn_in_t                sample,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [vn_pkg::THRESH_W-1:0]   cfg_data,
	output logic                          done,
	output vn_pkg::vn_out_t               result
);

	localparam int SW = vn_pkg::SAMPLE_W;
	localparam int NW = vn_pkg::NUM_W;
	localparam int QW = vn_pkg::ROOT_W;

	logic [vn_pkg::THRESH_W-1:0] thresh_q;

	logic                     valid_s1;
	logic [2*SW-1:0]          sq_s1 [3];
	vn_pkg::vn_side_t         side_s1;

	logic                     valid_s2;
	logic [vn_pkg::SUMSQ_W-1:0] sum_s2;
	vn_pkg::vn_side_t         side_s2;

	logic                     sq_valid;
	logic [QW-1:0]            sq_root;
	vn_pkg::vn_side_t         sq_side;

	logic                     dv_valid;
	logic [QW-1:0]            dv_mag;
	logic [2:0]               dv_neg;
	logic                     dv_zero;
	logic [QW-1:0]            dv_quot [3];

	logic                     done_q;
	vn_pkg::vn_out_t          result_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= vn_pkg::THRESH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			thresh_q <= cfg_data;
		end
	end

	// stage 1: squares, magnitudes and numerators |c| * 32767
	logic signed [SW-1:0] comp [3];
	logic [SW-1:0]        cabs [3];
	logic [NW-1:0]        cnum [3];

	assign comp[0] = sample.sample_x;
	assign comp[1] = sample.sample_y;
	assign comp[2] = sample.sample_z;

	for (genvar l = 0; l < 3; l++) begin : g_abs
		assign cabs[l] = comp[l][SW-1] ? SW'(-comp[l]) : SW'(comp[l]);
		assign cnum[l] = (NW'(cabs[l]) << 15) - NW'(cabs[l]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		sq_s1[0]      <= (2*SW)'(cabs[0]) * (2*SW)'(cabs[0]);
		sq_s1[1]      <= (2*SW)'(cabs[1]) * (2*SW)'(cabs[1]);
		sq_s1[2]      <= (2*SW)'(cabs[2]) * (2*SW)'(cabs[2]);
		side_s1.zero  <= (comp[0] == '0) && (comp[1] == '0) && (comp[2] == '0);
		side_s1.neg   <= {comp[2][SW-1], comp[1][SW-1], comp[0][SW-1]};
		side_s1.num_x <= cnum[0];
		side_s1.num_y <= cnum[1];
		side_s1.num_z <= cnum[2];
	end

	// stage 2: sum of squares
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		sum_s2  <= sq_s1[0] + sq_s1[1] + sq_s1[2];
		side_s2 <= side_s1;
	end

	vn_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_in  (valid_s2),
		.arg       (sum_s2),
		.side_in   (side_s2),
		.valid_out (sq_valid),
		.root      (sq_root),
		.side_out  (sq_side)
	);

	vn_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_in  (sq_valid),
		.mag_in    (sq_root),
		.side_in   (sq_side),
		.valid_out (dv_valid),
		.mag_out   (dv_mag),
		.neg_out   (dv_neg),
		.zero_out  (dv_zero),
		.quot      (dv_quot)
	);

	// output stage: clamp, restore sign, threshold compare
	logic [QW-1:0]        qclamp [3];
	logic signed [15:0]   unit   [3];

	for (genvar l = 0; l < 3; l++) begin : g_out
		assign qclamp[l] = (dv_quot[l] > vn_pkg::Q15_ONE) ? vn_pkg::Q15_ONE : dv_quot[l];
		assign unit[l]   = dv_zero ? 16'sd0
			: (dv_neg[l] ? 16'(-qclamp[l]) : 16'(qclamp[l]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		result_q.unit_x           <= unit[0];
		result_q.unit_y           <= unit[1];
		result_q.unit_z           <= unit[2];
		result_q.vector_magnitude <= dv_zero ? '0 : dv_mag;
		result_q.too_aligned      <= !dv_zero && (qclamp[1] > QW'(thresh_q));
		result_q.zero_vector      <= dv_zero;
	end

	assign done   = done_q;
	assign result = result_q;

endmodule
